[src/osm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_pkg
// shared types and constants for the order statistic multiset
// ----------------------------------------------------------------------------
package osm_pkg;

  localparam int DefaultCapacity = 64;
  localparam int KeyW            = 32;
  localparam int RankW           = 16;
  localparam int CountW          = 7;

  typedef logic signed [KeyW-1:0] key_t;

  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_ERASE      = 2'd1,
    OP_KTH        = 2'd2,
    OP_COUNT_LESS = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_RANK  = 2'd3
  } status_e;

  typedef struct packed {
    op_e              op;
    key_t             key;
    logic [RankW-1:0] rank;
  } req_t;

  typedef struct packed {
    status_e           status;
    key_t              value;
    logic [CountW-1:0] less_count;
    logic [CountW-1:0] occupancy;
  } rsp_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic ins_en;
    logic del_en;
    key_t key;
  } cell_ctrl_t;

endpackage

[src/order_statistic_multiset_core.sv]
`timescale 1ns / 1ps
// a request is accepted into the request register and executes from there into the response
// register; execution waits while a stalled response still holds that register
// throughput: one request per cycle while the response side keeps up; every operation is
// a single pass over the cell row (parallel compare, shift and rank encode)
// reset: asynchronous active low, clears the occupancy count and the handshake state;
// key cells hold no reset value and are only read below the occupancy count
// ----------------------------------------------------------------------------
// order_statistic_multiset_core
// bounded sorted multiset of signed keys in a row of shifting cells, with
// insert, erase, kth smallest and count-less queries
// ----------------------------------------------------------------------------
module order_statistic_multiset_core #(
  parameter int CAPACITY = osm_pkg::DefaultCapacity
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  osm_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output osm_pkg::rsp_t rsp_o
);

  localparam int CntW = $clog2(CAPACITY + 1);

  // request register and handshake state
  logic          busy_q, busy_d;
  osm_pkg::req_t req_q;
  logic          rsp_valid_q, rsp_valid_d;
  osm_pkg::rsp_t rsp_q, rsp_d;
  logic [CntW-1:0] count_q, count_d;

  logic accept;
  logic fire;

  // cell row signals
  osm_pkg::cell_ctrl_t ctrl;
  osm_pkg::key_t       cell_key [CAPACITY];
  logic [CAPACITY-1:0] occ_vec;
  logic [CAPACITY-1:0] ge_vec;
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;

  logic            found;
  logic            not_full;
  logic            rank_bad;
  osm_pkg::key_t   kth_value;
  logic [CntW-1:0] less_cnt;
  logic [CAPACITY+1:0] lt_ext;

  // ---------------------------------------------------------------------------
  // handshake: the request register frees up in the same cycle it executes,
  // and execution only waits when the response register is held by a stall
  // ---------------------------------------------------------------------------
  assign fire        = busy_q && (!rsp_valid_q || !rsp_stall_i);
  assign req_stall_o = busy_q && !fire;
  assign accept      = req_valid_i && !req_stall_o;

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (fire) begin
      busy_d = 1'b0;
    end
    rsp_valid_d = rsp_valid_q;
    if (fire) begin
      rsp_valid_d = 1'b1;
    end else if (!rsp_stall_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // cell row: cell i is occupied below the count; ge is a suffix of the row,
  // lt a prefix, so the row stays sorted under single-step shifts
  // ---------------------------------------------------------------------------
  assign not_full = (count_q < CntW'(CAPACITY));
  assign found    = |eq_vec;

  always_comb begin
    ctrl.key    = req_q.key;
    ctrl.ins_en = fire && (req_q.op == osm_pkg::OP_INSERT) && not_full;
    ctrl.del_en = fire && (req_q.op == osm_pkg::OP_ERASE) && found;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic          left_ge;
    osm_pkg::key_t left_key;
    osm_pkg::key_t right_key;

    assign occ_vec[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_ge  = 1'b0;
      assign left_key = cell_key[i];
    end else begin : g_mid
      assign left_ge  = ge_vec[i-1];
      assign left_key = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    osm_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ_vec[i]),
      .left_ge_i   (left_ge),
      .left_key_i  (left_key),
      .right_key_i (right_key),
      .key_o       (cell_key[i]),
      .ge_o        (ge_vec[i]),
      .lt_o        (lt_vec[i]),
      .eq_o        (eq_vec[i])
    );
  end

  // ---------------------------------------------------------------------------
  // queries
  // kth: each cell matches its own one-based position against the rank
  // count-less: lt is a thermometer, so the count is the index of its edge,
  // taken as an or of the one-hot edge position
  // ---------------------------------------------------------------------------
  assign rank_bad = (req_q.rank == '0) ||
                    (32'(req_q.rank) > 32'(count_q));
  assign lt_ext   = {1'b0, lt_vec, 1'b1};

  always_comb begin
    kth_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (req_q.rank == osm_pkg::RankW'(i + 1)) begin
        kth_value = kth_value | cell_key[i];
      end
    end
  end

  always_comb begin
    less_cnt = '0;
    for (int i = 0; i <= CAPACITY; i++) begin
      if (lt_ext[i] && !lt_ext[i+1]) begin
        less_cnt = less_cnt | CntW'(i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // response build and count update
  // ---------------------------------------------------------------------------
  always_comb begin
    count_d           = count_q;
    rsp_d             = rsp_q;
    if (fire) begin
      rsp_d.status     = osm_pkg::ST_OK;
      rsp_d.value      = '0;
      rsp_d.less_count = '0;
      case (req_q.op)
        osm_pkg::OP_INSERT: begin
          if (not_full) begin
            count_d = count_q + CntW'(1);
          end else begin
            rsp_d.status = osm_pkg::ST_FULL;
          end
        end
        osm_pkg::OP_ERASE: begin
          if (found) begin
            count_d = count_q - CntW'(1);
          end else begin
            rsp_d.status = osm_pkg::ST_NOT_FOUND;
          end
        end
        osm_pkg::OP_KTH: begin
          if (rank_bad) begin
            rsp_d.status = osm_pkg::ST_BAD_RANK;
            rsp_d.value  = '1;
          end else begin
            rsp_d.value = kth_value;
          end
        end
        osm_pkg::OP_COUNT_LESS: begin
          rsp_d.less_count = osm_pkg::CountW'(less_cnt);
        end
        default: begin
          rsp_d.status = osm_pkg::ST_OK;
        end
      endcase
      rsp_d.occupancy = osm_pkg::CountW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      rsp_valid_q <= rsp_valid_d;
      count_q     <= count_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTHESIS
  // occupancy never exceeds the row length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("occupancy count above capacity");

  // a response only appears after a request was executing
  a_rsp_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(busy_q))
    else $error("response without executed request");

  // a missed erase leaves the count alone
  a_erase_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (req_q.op == osm_pkg::OP_ERASE) && !found) |=> (count_q == $past(count_q)))
    else $error("count changed on erase of absent key");

  // queries never change the count
  a_query_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ((req_q.op == osm_pkg::OP_KTH) || (req_q.op == osm_pkg::OP_COUNT_LESS)))
    |=> (count_q == $past(count_q)))
    else $error("count changed on query");
`endif

endmodule

[src/osm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_cell
// one slot of the sorted key row: compares against the broadcast key and
// shifts toward either neighbor on insert or erase
// ----------------------------------------------------------------------------
module osm_cell (
  input  logic                  clk_i,
  input  osm_pkg::cell_ctrl_t   ctrl_i,
  input  logic                  occ_i,
  input  logic                  left_ge_i,
  input  osm_pkg::key_t         left_key_i,
  input  osm_pkg::key_t         right_key_i,
  output osm_pkg::key_t         key_o,
  output logic                  ge_o,
  output logic                  lt_o,
  output logic                  eq_o
);

  osm_pkg::key_t key_q, key_d;
  logic          gt;

  always_comb begin
    lt_o = occ_i && ($signed(key_q) < $signed(ctrl_i.key));
    eq_o = occ_i && (key_q == ctrl_i.key);
    gt   = occ_i && ($signed(key_q) > $signed(ctrl_i.key));
    // free slots count as above the key, so ge forms a suffix of the row
    ge_o = gt || !occ_i;
  end

  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins_en) begin
      if (left_ge_i) begin
        key_d = left_key_i;
      end else if (ge_o) begin
        key_d = ctrl_i.key;
      end
    end
    if (ctrl_i.del_en && !lt_o) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule
